FILE: rtl/header_field_extractor_top_macros.svh
// ----------------------------------------------------------------------------
// header_field_extractor_top_macros.svh
// Assertion macros used by the checker file of the header field extractor.
// ----------------------------------------------------------------------------
`ifndef HEADER_FIELD_EXTRACTOR_TOP_MACROS_SVH
`define HEADER_FIELD_EXTRACTOR_TOP_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define HFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hfe assertion failed");

// Check a property on every clock edge, reset cycles included.
`define HFE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hfe assertion failed");

`endif

FILE: rtl/hfe_pkg.sv
// ----------------------------------------------------------------------------
// hfe_pkg
// Types and constants of the header field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package hfe_pkg;

  localparam int ByteW    = 8;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 2;
  localparam int KeyLenW  = 5;
  localparam int BytesPerWord = CfgDataW / ByteW;

  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [KeyLenW-1:0]  key_len_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  localparam byte_t CH_COLON   = 8'h3A;
  localparam byte_t CH_SPACE   = 8'h20;
  localparam byte_t CH_NEWLINE = 8'h0A;

endpackage

`default_nettype wire

FILE: rtl/hfe_key_store.sv
// ----------------------------------------------------------------------------
// hfe_key_store
// Key configuration registers, key character select and clamped key length.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_key_store #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [hfe_pkg::CfgIdxW-1:0]            cfg_index,
  input  wire hfe_pkg::cfg_data_t                     cfg_wdata,
  input  wire logic [$clog2(MAX_KEY_BYTES+1)-1:0]     rd_pos,
  output hfe_pkg::byte_t                              rd_char,
  output logic [$clog2(MAX_KEY_BYTES+1)-1:0]          key_len
);
  import hfe_pkg::*;

  localparam int PosW = $clog2(MAX_KEY_BYTES + 1);
  localparam int IdxW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  byte_t    key_r [MAX_KEY_BYTES];
  key_len_t len_r;

  // Characters 0..7 come from the low word, 8..15 from the high word.
  for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_key
    localparam cfg_idx_t SrcIdx = (i < BytesPerWord) ? CFG_KEY_LOW : CFG_KEY_HIGH;
    localparam int       Lsb    = (i % BytesPerWord) * ByteW;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_r[i] <= '0;
      end else if (cfg_we && (cfg_index == SrcIdx)) begin
        key_r[i] <= cfg_wdata[Lsb +: ByteW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we && (cfg_index == CFG_KEY_LEN)) begin
      len_r <= cfg_wdata[KeyLenW-1:0];
    end
  end

  // Only read while rd_pos is below key_len, so the index is always in range.
  assign rd_char = key_r[rd_pos[IdxW-1:0]];

  // Clamp oversized lengths to the key storage depth.
  always_comb begin
    if (len_r > KeyLenW'(MAX_KEY_BYTES)) begin
      key_len = PosW'(MAX_KEY_BYTES);
    end else begin
      key_len = len_r[PosW-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/header_field_extractor_top.sv
// An accepted item passes through the input register and then the result register to the out_ ports.
// One request byte per clock while out_ready does not stall; the scan state updates from one byte to the next.
// Backpressure on out_ready stalls the input register, and through it in_ready.
// Reset (rst_n low, synchronous) clears the key registers, the scan state and both
// valid flags; the block is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
// header_field_extractor_top
// Scans a request byte stream, finds the first line whose start is the
// configured key followed by a colon, and streams out that line's value with
// spaces dropped; a request without such a line ends with a not-found marker.
// ----------------------------------------------------------------------------
`default_nettype none

module header_field_extractor_top #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [hfe_pkg::CfgIdxW-1:0] cfg_index,
  input  wire hfe_pkg::cfg_data_t          cfg_wdata,
  // request byte items
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire hfe_pkg::byte_t              in_data_byte,
  input  wire logic                        in_request_end,
  // value result items
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output hfe_pkg::byte_t                   out_value_byte,
  output logic                             out_byte_valid,
  output logic                             out_value_end,
  output logic                             out_found
);
  import hfe_pkg::*;

  localparam int PosW = $clog2(MAX_KEY_BYTES + 1);

  // --------------------------------------------------------------------------
  // Key registers
  // --------------------------------------------------------------------------
  logic [PosW-1:0] pos_r;
  logic [PosW-1:0] pos_nxt;
  logic [PosW-1:0] key_len;
  byte_t           key_char;

  hfe_key_store #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_key_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rd_pos    (pos_r),
    .rd_char   (key_char),
    .key_len   (key_len)
  );

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic  in_valid_r;
  byte_t in_byte_r;
  logic  in_end_r;
  logic  advance;   // the result register can take a new result this cycle
  logic  fire;      // the held item is processed this cycle

  assign advance  = !out_valid || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload needs no reset; load on every accept.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_end_r  <= in_request_end;
    end
  end

  // --------------------------------------------------------------------------
  // Scan state and per-byte decision
  // --------------------------------------------------------------------------
  phase_t phase_r;
  phase_t phase_nxt;
  logic   emit;
  byte_t  res_byte;
  logic   res_byte_valid;
  logic   res_end;
  logic   res_found;
  logic   is_nl;
  logic   key_hit;
  logic   colon_hit;

  assign is_nl     = (in_byte_r == CH_NEWLINE);
  assign key_hit   = (pos_r < key_len) && !is_nl && (in_byte_r == key_char);
  assign colon_hit = (pos_r == key_len) && (in_byte_r == CH_COLON);

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    emit           = 1'b0;
    res_byte       = '0;
    res_byte_valid = 1'b0;
    res_end        = 1'b0;
    res_found      = 1'b0;

    case (phase_r)
      PH_MATCH: begin
        // advance through the key, take the colon, restart on newline,
        // otherwise drop the rest of the line
        if (key_hit) begin
          pos_nxt = pos_r + 1'b1;
        end else if (colon_hit) begin
          phase_nxt = PH_VALUE;
        end else if (is_nl) begin
          pos_nxt = '0;
        end else begin
          phase_nxt = PH_SKIP;
        end
        if (in_end_r) begin
          emit      = 1'b1;
          res_end   = 1'b1;
          res_found = colon_hit && !key_hit;
        end
      end
      PH_SKIP: begin
        if (is_nl) begin
          phase_nxt = PH_MATCH;
          pos_nxt   = '0;
        end
        if (in_end_r) begin
          emit    = 1'b1;
          res_end = 1'b1;
        end
      end
      PH_VALUE: begin
        if (is_nl) begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
          res_end   = 1'b1;
          res_found = 1'b1;
        end else if (in_byte_r == CH_SPACE) begin
          // drop spaces, but a final space still closes the value
          if (in_end_r) begin
            emit      = 1'b1;
            res_end   = 1'b1;
            res_found = 1'b1;
          end
        end else begin
          emit           = 1'b1;
          res_byte       = in_byte_r;
          res_byte_valid = 1'b1;
          res_end        = in_end_r;
          res_found      = 1'b1;
        end
      end
      PH_DONE: begin
        // value already closed: hold until the request ends
      end
      default: begin
        phase_nxt = PH_MATCH;
      end
    endcase

    // every request starts over from line start
    if (in_end_r) begin
      phase_nxt = PH_MATCH;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MATCH;
      pos_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value_byte <= res_byte;
      out_byte_valid <= res_byte_valid;
      out_value_end  <= res_end;
      out_found      <= res_found;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hfe_checker.sv
// ----------------------------------------------------------------------------
// hfe_checker
// Port-level checks of the header field extractor result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "header_field_extractor_top_macros.svh"

module hfe_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire hfe_pkg::byte_t              out_value_byte,
  input wire logic                        out_byte_valid,
  input wire logic                        out_value_end,
  input wire logic                        out_found
);
  import hfe_pkg::*;

  logic [ByteW+2:0] out_payload;
  logic             bare_end;
  logic             blank_byte;

  assign out_payload = {out_value_byte, out_byte_valid, out_value_end, out_found};
  assign bare_end    = out_value_end && !out_byte_valid && (out_value_byte == '0);
  assign blank_byte  = (out_value_byte == CH_SPACE) || (out_value_byte == CH_NEWLINE);

  // a stalled result holds
  `HFE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload))

  // a not-found marker is a bare end
  `HFE_ASSERT(a_not_found_bare, out_valid && !out_found |-> bare_end)

  // value bytes never carry a space or a newline
  `HFE_ASSERT(a_value_clean, out_valid && out_byte_valid |-> !blank_byte)

  // reset drops any pending result
  `HFE_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid)

endmodule

bind header_field_extractor_top hfe_checker u_hfe_checker (.*);

`default_nettype wire
